// ===== rtl/dtbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual token bucket policer package
// Shared widths, constants, register indexes and the control and status
// structures passed between the top level and the bucket sequencers.
// ----------------------------------------------------------------------------
package dtbp_pkg;

  // Field and datapath widths.
  localparam int TIME_BITS  = 64;   // nanosecond timestamp
  localparam int RATE_BITS  = 32;   // rate and burst registers
  localparam int LEN_BITS   = 32;   // packet length in bytes
  localparam int FRAC_BITS  = 30;   // sub-token remainder, always below one second
  localparam int SEC_BITS   = 35;   // whole seconds in any 64-bit nanosecond span
  localparam int PROD_BITS  = SEC_BITS + RATE_BITS;
  localparam int PRELOAD_BITS = TIME_BITS - SEC_BITS;

  // Serial step counts.
  localparam int DIGIT_BITS     = 8;
  localparam int DIFF_STEPS     = TIME_BITS / DIGIT_BITS;
  localparam int DIFF_CNT_BITS  = $clog2(DIFF_STEPS);
  localparam int SERIAL_STEPS   = SEC_BITS;
  localparam int STEP_CNT_BITS  = $clog2(SERIAL_STEPS);

  // Nanoseconds in one second.
  localparam logic [FRAC_BITS-1:0] NS_PER_SEC = 30'd1_000_000_000;

  // Configuration register indexes.
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_PACKET_RATE  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_PACKET_BURST = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_BYTE_RATE    = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_BYTE_BURST   = 2'd3;

  // Control from the top level to one bucket.
  typedef struct packed {
    logic start;   // begin refill and spend evaluation for the held item
    logic reload;  // fill the bucket to its capacity, clear the remainder
    logic commit;  // finish the evaluation and leave the done state
    logic apply;   // with commit: write the evaluated tokens back
  } bkt_ctl_t;

  // Status from one bucket to the top level.
  typedef struct packed {
    logic done;    // evaluation finished, waiting for commit
    logic pass;    // the amount fits in the refilled bucket
  } bkt_status_t;

endpackage

// ===== rtl/dual_token_bucket_policer_unit.sv =====
// ----------------------------------------------------------------------------
// Dual token bucket policer
// Polices packets against a packet-count bucket and a byte bucket, each
// refilled from the elapsed time at its own rate and capped at its burst.
// ----------------------------------------------------------------------------
// One packet item is taken at a time. Both buckets evaluate side by side.
// Every item runs an 8-digit time subtraction; a bucket that refills then
// runs at most a 35-step serial divide by 1e9, a 35-step serial multiply by
// the rate for whole seconds, a second 35-step multiply for the nanoseconds
// and a second 35-step divide. The byte bucket is written back only when the
// packet bucket passes; the packet token is not refunded when the byte bucket
// rejects. Writing a burst register sets a reload flag that refills that
// bucket to its capacity unless an applied commit writes that bucket back in
// the same cycle. The result register lets a finished result wait while the
// next packet is accepted.
// ----------------------------------------------------------------------------
module dual_token_bucket_policer_unit #(
  parameter int TOKEN_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [dtbp_pkg::REG_IDX_BITS-1:0]      cfg_index,
  input  logic [dtbp_pkg::RATE_BITS-1:0]         cfg_data,
  input  logic                                   pkt_valid,
  output logic                                   pkt_stall,
  input  logic [dtbp_pkg::TIME_BITS-1:0]         now_ns,
  input  logic [dtbp_pkg::LEN_BITS-1:0]          byte_count,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic                                   accepted
);

  localparam logic T_IDLE = 1'b0;
  localparam logic T_RUN  = 1'b1;

  logic                                state;
  logic [dtbp_pkg::RATE_BITS-1:0]      packet_rate;
  logic [dtbp_pkg::RATE_BITS-1:0]      packet_burst;
  logic [dtbp_pkg::RATE_BITS-1:0]      byte_rate;
  logic [dtbp_pkg::RATE_BITS-1:0]      byte_burst;
  logic                                reload_pkt;
  logic                                reload_byte;
  logic                                start_r;
  logic [dtbp_pkg::TIME_BITS-1:0]      now_r;
  logic [dtbp_pkg::LEN_BITS-1:0]       len_r;
  logic                                commit_go;
  dtbp_pkg::bkt_ctl_t                  pkt_ctl;
  dtbp_pkg::bkt_ctl_t                  byte_ctl;
  dtbp_pkg::bkt_status_t               pkt_st;
  dtbp_pkg::bkt_status_t               byte_st;

  // Configuration registers; a burst write schedules a refill to capacity.
  // The reload flags start set so that both buckets fill after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_rate  <= 32'd1000;
      packet_burst <= 32'd2000;
      byte_rate    <= 32'd1048576;
      byte_burst   <= 32'd2097152;
      reload_pkt   <= 1'b1;
      reload_byte  <= 1'b1;
    end else begin
      reload_pkt  <= 1'b0;
      reload_byte <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          dtbp_pkg::REG_PACKET_RATE:  packet_rate <= cfg_data;
          dtbp_pkg::REG_PACKET_BURST: begin
            packet_burst <= cfg_data;
            reload_pkt   <= 1'b1;
          end
          dtbp_pkg::REG_BYTE_RATE:    byte_rate <= cfg_data;
          dtbp_pkg::REG_BYTE_BURST:   begin
            byte_burst  <= cfg_data;
            reload_byte <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Both buckets are done and the result register can take the outcome.
  assign commit_go = (state == T_RUN) && pkt_st.done && byte_st.done
                   && (!res_valid || !res_stall);

  assign pkt_stall = (state != T_IDLE);

  // Item capture, sequencing and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      start_r   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      start_r <= 1'b0;
      // A new outcome takes the result register as the old one leaves.
      if (commit_go) begin
        res_valid <= 1'b1;
        accepted  <= pkt_st.pass && byte_st.pass;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (pkt_valid) begin
            now_r   <= now_ns;
            len_r   <= byte_count;
            start_r <= 1'b1;
            state   <= T_RUN;
          end
        end
        T_RUN: begin
          if (commit_go) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // The byte bucket keeps its old state when the packet bucket rejects.
  assign pkt_ctl.start   = start_r;
  assign pkt_ctl.reload  = reload_pkt;
  assign pkt_ctl.commit  = commit_go;
  assign pkt_ctl.apply   = 1'b1;
  assign byte_ctl.start  = start_r;
  assign byte_ctl.reload = reload_byte;
  assign byte_ctl.commit = commit_go;
  assign byte_ctl.apply  = pkt_st.pass;

  dtbp_bucket #(
    .TOKEN_BITS (TOKEN_BITS)
  ) u_pkt_bucket (
    .clk    (clk),
    .rst    (rst),
    .ctl    (pkt_ctl),
    .rate   (packet_rate),
    .burst  (packet_burst),
    .now    (now_r),
    .amount (dtbp_pkg::LEN_BITS'(1)),
    .status (pkt_st)
  );

  dtbp_bucket #(
    .TOKEN_BITS (TOKEN_BITS)
  ) u_byte_bucket (
    .clk    (clk),
    .rst    (rst),
    .ctl    (byte_ctl),
    .rate   (byte_rate),
    .burst  (byte_burst),
    .now    (now_r),
    .amount (len_r),
    .status (byte_st)
  );

`ifndef SYNTHESIS
  // A commit presents the combined verdict of both buckets next cycle.
  assert property (@(posedge clk) disable iff (rst)
    commit_go |=> (res_valid && (accepted == $past(pkt_st.pass && byte_st.pass))))
    else $error("result does not match the bucket verdicts");
`endif

endmodule

// ===== rtl/dtbp_divider.sv =====
// ----------------------------------------------------------------------------
// Serial divider by one second
// Restoring division of a 64-bit nanosecond value by 1e9, one quotient bit
// per cycle, giving whole seconds and the nanosecond remainder.
// ----------------------------------------------------------------------------
module dtbp_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [dtbp_pkg::TIME_BITS-1:0]       dividend,
  output logic                                 done,
  output logic [dtbp_pkg::SEC_BITS-1:0]        quot,
  output logic [dtbp_pkg::FRAC_BITS-1:0]       rem
);

  logic                                  busy;
  logic [dtbp_pkg::STEP_CNT_BITS-1:0]    cnt;
  logic [dtbp_pkg::FRAC_BITS-1:0]        rem_r;
  logic [dtbp_pkg::SEC_BITS-1:0]         dq;
  logic [dtbp_pkg::FRAC_BITS:0]          trial;
  logic                                  trial_ge;
  logic [dtbp_pkg::FRAC_BITS:0]          trial_sub;

  // One restoring step: bring down the next dividend bit and try 1e9.
  assign trial     = {rem_r, dq[dtbp_pkg::SEC_BITS-1]};
  assign trial_ge  = trial >= {1'b0, dtbp_pkg::NS_PER_SEC};
  assign trial_sub = trial - {1'b0, dtbp_pkg::NS_PER_SEC};

  // The top dividend bits are below 1e9 and go straight into the remainder;
  // the dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem_r <= dtbp_pkg::FRAC_BITS'(dividend[dtbp_pkg::TIME_BITS-1:dtbp_pkg::SEC_BITS]);
        dq    <= dividend[dtbp_pkg::SEC_BITS-1:0];
      end else if (busy) begin
        rem_r <= trial_ge ? trial_sub[dtbp_pkg::FRAC_BITS-1:0]
                          : trial[dtbp_pkg::FRAC_BITS-1:0];
        dq    <= {dq[dtbp_pkg::SEC_BITS-2:0], trial_ge};
        cnt   <= cnt + 1'b1;
        if (cnt == dtbp_pkg::STEP_CNT_BITS'(dtbp_pkg::SERIAL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = dq;
  assign rem  = rem_r;

`ifndef SYNTHESIS
  // The remainder handed out is always a valid nanosecond count.
  assert property (@(posedge clk) disable iff (rst) done |-> (rem < dtbp_pkg::NS_PER_SEC))
    else $error("divider remainder not below one second");
`endif

endmodule

// ===== rtl/dtbp_multiplier.sv =====
// ----------------------------------------------------------------------------
// Serial rate multiplier
// Serial-parallel multiply-add: the multiplier is consumed one bit per cycle
// and product bits leave the bottom of the accumulator into a shift register.
// ----------------------------------------------------------------------------
module dtbp_multiplier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [dtbp_pkg::RATE_BITS-1:0]       mcand,
  input  logic [dtbp_pkg::SEC_BITS-1:0]        mplier,
  input  logic [dtbp_pkg::FRAC_BITS-1:0]       addend,
  output logic                                 done,
  output logic [dtbp_pkg::PROD_BITS-1:0]       product
);

  logic                                  busy;
  logic [dtbp_pkg::STEP_CNT_BITS-1:0]    cnt;
  logic [dtbp_pkg::RATE_BITS-1:0]        acc;
  logic [dtbp_pkg::SEC_BITS-1:0]         pl;
  logic [dtbp_pkg::RATE_BITS:0]          sum;

  // Add the multiplicand when the current multiplier bit is set.
  assign sum = {1'b0, acc} + (pl[0] ? {1'b0, mcand} : '0);

  // The accumulator starts at the addend, so the result is mcand*mplier+addend.
  // The user must hold the multiplicand configuration register during the run.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= dtbp_pkg::RATE_BITS'(addend);
        pl   <= mplier;
      end else if (busy) begin
        acc <= sum[dtbp_pkg::RATE_BITS:1];
        pl  <= {sum[0], pl[dtbp_pkg::SEC_BITS-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == dtbp_pkg::STEP_CNT_BITS'(dtbp_pkg::SERIAL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = {acc, pl};

endmodule

// ===== rtl/dtbp_bucket.sv =====
// ----------------------------------------------------------------------------
// Token bucket sequencer
// Holds one bucket's tokens, remainder and last update time, works out the
// refill for an item with a serial subtractor, divider and multiplier, and
// writes the bucket back, spent if the item passes, on an applied commit.
// ----------------------------------------------------------------------------
module dtbp_bucket #(
  parameter int TOKEN_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dtbp_pkg::bkt_ctl_t                 ctl,
  input  logic [dtbp_pkg::RATE_BITS-1:0]     rate,
  input  logic [dtbp_pkg::RATE_BITS-1:0]     burst,
  input  logic [dtbp_pkg::TIME_BITS-1:0]     now,
  input  logic [dtbp_pkg::LEN_BITS-1:0]      amount,
  output dtbp_pkg::bkt_status_t              status
);

  // Common width for capacity and amount comparisons.
  localparam int CW = (TOKEN_BITS > dtbp_pkg::RATE_BITS) ? TOKEN_BITS : dtbp_pkg::RATE_BITS;
  localparam logic [CW-1:0] MAX_TOK = CW'((65'd1 << TOKEN_BITS) - 65'd1);
  localparam int PW = dtbp_pkg::PROD_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIFF   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_DIV1   = 4'd3;
  localparam logic [3:0] S_MUL1   = 4'd4;
  localparam logic [3:0] S_CHK1   = 4'd5;
  localparam logic [3:0] S_MUL2   = 4'd6;
  localparam logic [3:0] S_DIV2   = 4'd7;
  localparam logic [3:0] S_CHK2   = 4'd8;
  localparam logic [3:0] S_SPEND  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]                              state;
  logic [dtbp_pkg::DIFF_CNT_BITS-1:0]      step_cnt;
  logic [dtbp_pkg::TIME_BITS-1:0]          elapsed;
  logic                                    borrow;
  logic                                    nonzero;
  logic [TOKEN_BITS-1:0]                   tokens;
  logic [dtbp_pkg::FRAC_BITS-1:0]          fraction;
  logic [dtbp_pkg::TIME_BITS-1:0]          last_time;
  logic [TOKEN_BITS-1:0]                   tok_w;
  logic [dtbp_pkg::FRAC_BITS-1:0]          frac_w;
  logic                                    upd_time;
  logic                                    pass_r;
  logic                                    div_start;
  logic                                    mul_start;

  logic [CW-1:0]                           burst_cw;
  logic [CW-1:0]                           cap_cw;
  logic [TOKEN_BITS-1:0]                   cap_tok;
  logic [TOKEN_BITS-1:0]                   missing_now;
  logic [TOKEN_BITS-1:0]                   missing_w;
  logic [dtbp_pkg::DIGIT_BITS:0]           diff_digit;
  logic                                    refill;
  logic [CW-1:0]                           tok_cw;
  logic [CW-1:0]                           amount_cw;
  logic [CW-1:0]                           spent_cw;
  logic [PW-1:0]                           sum_sec;
  logic [PW-1:0]                           sum_ns;

  logic [dtbp_pkg::TIME_BITS-1:0]          div_dividend;
  logic                                    div_done;
  logic [dtbp_pkg::SEC_BITS-1:0]           div_quot;
  logic [dtbp_pkg::FRAC_BITS-1:0]          div_rem;
  logic [dtbp_pkg::SEC_BITS-1:0]           mul_b;
  logic [dtbp_pkg::FRAC_BITS-1:0]          mul_add;
  logic                                    mul_done;
  logic [PW-1:0]                           mul_product;

  // Capacity is the burst saturated to the token width.
  assign burst_cw = CW'(burst);
  assign cap_cw   = (burst_cw > MAX_TOK) ? MAX_TOK : burst_cw;
  assign cap_tok  = cap_cw[TOKEN_BITS-1:0];

  assign missing_now = cap_tok - tokens;
  assign missing_w   = cap_tok - tok_w;

  // One digit of now minus last time, least significant digit first.
  assign diff_digit = {1'b0, elapsed[dtbp_pkg::DIGIT_BITS-1:0]}
                    - {1'b0, last_time[dtbp_pkg::DIGIT_BITS-1:0]}
                    - {{dtbp_pkg::DIGIT_BITS{1'b0}}, borrow};

  // Refill when time moved forward (no borrow, not zero) and the rate is not zero.
  assign refill = !borrow && nonzero && (rate != '0);

  // Token additions and the final spend.
  assign sum_sec   = PW'(tok_w) + mul_product;
  assign sum_ns    = PW'(tok_w) + PW'(div_quot);
  assign tok_cw    = CW'(tok_w);
  assign amount_cw = CW'(amount);
  assign spent_cw  = tok_cw - amount_cw;

  // Operand selection for the shared serial units.
  assign div_dividend = (state == S_DIV2) ? mul_product[dtbp_pkg::TIME_BITS-1:0] : elapsed;
  assign mul_b        = (state == S_MUL2) ? dtbp_pkg::SEC_BITS'(div_rem) : div_quot;
  assign mul_add      = (state == S_MUL2) ? fraction : '0;

  dtbp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  dtbp_multiplier u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (rate),
    .mplier  (mul_b),
    .addend  (mul_add),
    .done    (mul_done),
    .product (mul_product)
  );

  // Sequencer and bucket state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      mul_start <= 1'b0;
      fraction  <= '0;
      last_time <= '0;
    end else begin
      div_start <= 1'b0;
      mul_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            elapsed  <= now;
            borrow   <= 1'b0;
            nonzero  <= 1'b0;
            step_cnt <= '0;
            state    <= S_DIFF;
          end
        end
        // The last time rotates a full turn, so it comes back unchanged.
        S_DIFF: begin
          elapsed   <= {diff_digit[dtbp_pkg::DIGIT_BITS-1:0],
                        elapsed[dtbp_pkg::TIME_BITS-1:dtbp_pkg::DIGIT_BITS]};
          last_time <= {last_time[dtbp_pkg::DIGIT_BITS-1:0],
                        last_time[dtbp_pkg::TIME_BITS-1:dtbp_pkg::DIGIT_BITS]};
          borrow    <= diff_digit[dtbp_pkg::DIGIT_BITS];
          nonzero   <= nonzero || (diff_digit[dtbp_pkg::DIGIT_BITS-1:0] != '0);
          step_cnt  <= step_cnt + 1'b1;
          if (step_cnt == dtbp_pkg::DIFF_CNT_BITS'(dtbp_pkg::DIFF_STEPS - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          tok_w <= tokens;
          if (!refill) begin
            frac_w   <= fraction;
            upd_time <= 1'b0;
            state    <= S_SPEND;
          end else if (missing_now == '0) begin
            frac_w   <= '0;
            upd_time <= 1'b1;
            state    <= S_SPEND;
          end else begin
            upd_time  <= 1'b1;
            div_start <= 1'b1;
            state     <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            mul_start <= 1'b1;
            state     <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_done) begin
            state <= S_CHK1;
          end
        end
        // Whole seconds alone may be enough to fill the bucket.
        S_CHK1: begin
          if (mul_product >= PW'(missing_w)) begin
            tok_w  <= cap_tok;
            frac_w <= '0;
            state  <= S_SPEND;
          end else begin
            tok_w     <= sum_sec[TOKEN_BITS-1:0];
            mul_start <= 1'b1;
            state     <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_done) begin
            div_start <= 1'b1;
            state     <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            state <= S_CHK2;
          end
        end
        // Tokens from the nanosecond part and the carried remainder.
        S_CHK2: begin
          if (PW'(div_quot) >= PW'(missing_w)) begin
            tok_w  <= cap_tok;
            frac_w <= '0;
          end else begin
            tok_w  <= sum_ns[TOKEN_BITS-1:0];
            frac_w <= div_rem;
          end
          state <= S_SPEND;
        end
        S_SPEND: begin
          pass_r <= amount_cw <= tok_cw;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (ctl.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Write-back on an applied commit, otherwise a capacity reload.
      if (state == S_DONE && ctl.commit && ctl.apply) begin
        tokens   <= pass_r ? spent_cw[TOKEN_BITS-1:0] : tok_w;
        fraction <= frac_w;
        if (upd_time) begin
          last_time <= now;
        end
      end else if (ctl.reload) begin
        tokens   <= cap_tok;
        fraction <= '0;
      end
    end
  end

  assign status.done = (state == S_DONE);
  assign status.pass = pass_r;

`ifndef SYNTHESIS
  // A settled bucket never holds more than its capacity.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !ctl.reload) |-> (tokens <= cap_tok))
    else $error("bucket tokens above capacity");

  // The carried remainder stays below one second's worth.
  assert property (@(posedge clk) disable iff (rst) fraction < dtbp_pkg::NS_PER_SEC)
    else $error("bucket remainder out of range");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual token bucket policer testbench
// Sends timestamped packet items into the policer and checks each pass or
// drop verdict against a bit-accurate model of the packet and byte buckets.
// A short directed run covers the edge cases, then random phases with fresh
// register settings follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TOKEN_BITS = 32;
  localparam logic [63:0] NS_IN_SEC = 64'd1_000_000_000;
  localparam logic [63:0] TIME_MAX = '1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT_RESULT = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PACKETS = 48;

  typedef struct {
    logic [63:0] tokens;
    logic [63:0] frac;
    logic [63:0] last;
  } bucket_t;

  typedef struct {
    logic [63:0] stamp;
    logic [31:0] nbytes;
  } packet_t;

  typedef struct {
    logic [63:0] stamp;
    logic [31:0] nbytes;
    logic        pass;
  } verdict_t;

  typedef enum {PROFILE_DEFAULTS, PROFILE_TIGHT, PROFILE_EXTREME, PROFILE_WIDE} profile_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [dtbp_pkg::REG_IDX_BITS-1:0] cfg_index = dtbp_pkg::REG_PACKET_RATE;
  logic [dtbp_pkg::RATE_BITS-1:0]    cfg_data = '0;
  logic                              pkt_valid = 1'b0;
  logic                              pkt_stall;
  logic [dtbp_pkg::TIME_BITS-1:0]    now_ns = '0;
  logic [dtbp_pkg::LEN_BITS-1:0]     byte_count = '0;
  logic                              res_valid;
  logic                              res_stall = 1'b0;
  logic                              accepted;

  // Local copy of the policy registers and of both buckets.
  logic [31:0] pkt_rate_q   = 32'd1000;
  logic [31:0] pkt_burst_q  = 32'd2000;
  logic [31:0] byte_rate_q  = 32'd1048576;
  logic [31:0] byte_burst_q = 32'd2097152;
  bucket_t     pkt_bkt;
  bucket_t     byte_bkt;

  packet_t  send_q[$];
  verdict_t verdict_q[$];
  int       mismatches = 0;
  int       results_seen = 0;
  bit       send_gaps = 1'b1;
  bit       recv_stalls = 1'b1;
  logic [63:0] wall_ns = '0;

  dual_token_bucket_policer_unit #(
    .TOKEN_BITS(TOKEN_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .now_ns    (now_ns),
    .byte_count(byte_count),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .accepted  (accepted)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bucket capacity is the burst saturated to the token width.
  function automatic logic [63:0] token_cap(input logic [31:0] burst);
    logic [63:0] most;
    most = (64'd1 << TOKEN_BITS) - 64'd1;
    return (64'(burst) > most) ? most : 64'(burst);
  endfunction

  // Refills one bucket from the elapsed time, then tries to take the amount.
  function automatic bit bucket_draw(inout bucket_t b, input logic [31:0] rate,
                                     input logic [31:0] burst, input logic [63:0] amount,
                                     input logic [63:0] stamp);
    logic [63:0] cap, elapsed, secs, nsecs, missing, to_fill, sum, whole, rate64;
    cap = token_cap(burst);
    rate64 = 64'(rate);
    if (b.tokens > cap) b.tokens = cap;
    if (stamp > b.last && rate64 != 0) begin
      elapsed = stamp - b.last;
      secs = elapsed / NS_IN_SEC;
      nsecs = elapsed % NS_IN_SEC;
      missing = cap - b.tokens;
      b.last = stamp;
      if (missing == 0) begin
        b.frac = 0;
      end else begin
        to_fill = missing / rate64;
        if (missing % rate64 != 0) to_fill = to_fill + 1;
        if (secs >= to_fill) begin
          b.tokens = cap;
          b.frac = 0;
        end else begin
          b.tokens = b.tokens + secs * rate64;
          missing = cap - b.tokens;
          sum = nsecs * rate64 + b.frac;
          whole = sum / NS_IN_SEC;
          if (whole >= missing) begin
            b.tokens = cap;
            b.frac = 0;
          end else begin
            b.tokens = b.tokens + whole;
            b.frac = sum % NS_IN_SEC;
          end
        end
      end
    end
    if (amount > b.tokens) return 1'b0;
    b.tokens = b.tokens - amount;
    return 1'b1;
  endfunction

  // The byte bucket is only consulted once the packet bucket has paid.
  function automatic bit police_packet(input logic [63:0] stamp, input logic [31:0] nbytes);
    if (!bucket_draw(pkt_bkt, pkt_rate_q, pkt_burst_q, 64'd1, stamp)) return 1'b0;
    return bucket_draw(byte_bkt, byte_rate_q, byte_burst_q, 64'(nbytes), stamp);
  endfunction

  // Idle length in cycles: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd1;
      default: return '1;
    endcase
  endfunction

  // Packet driver: offers queued items and predicts the verdict of each one taken.
  int send_gap = 0;
  always @(posedge clk) begin
    logic     busy;
    packet_t  nxt;
    verdict_t v;
    if (rst) begin
      pkt_valid <= 1'b0;
    end else begin
      busy = pkt_valid;
      if (pkt_valid && !pkt_stall) begin
        v.stamp = now_ns;
        v.nbytes = byte_count;
        v.pass = police_packet(now_ns, byte_count);
        verdict_q.push_back(v);
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          pkt_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          nxt = send_q.pop_front();
          pkt_valid <= 1'b1;
          now_ns <= nxt.stamp;
          byte_count <= nxt.nbytes;
          send_gap = send_gaps ? idle_len() : 0;
        end else begin
          pkt_valid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor: checks each item taken and drives random stalls, with one
  // long hold-off so that the policer backs up and stalls its input.
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    verdict_t want;
    int       n;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict with no packet outstanding: expected none, got accepted=%0b",
                   $time, accepted);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (accepted !== want.pass) begin
            $display("%0t: packet at %0d ns, %0d bytes: expected accepted=%0b, got %0b",
                     $time, want.stamp, want.nbytes, want.pass, accepted);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        n = recv_stalls ? idle_len() : 0;
        stall_left = (n > 0) ? n - 1 : 0;
        res_stall <= (n > 0);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (pkt_valid && !pkt_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write; the local copy follows at the edge the policer takes it.
  task automatic write_reg(input logic [dtbp_pkg::REG_IDX_BITS-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      dtbp_pkg::REG_PACKET_RATE: pkt_rate_q = val;
      dtbp_pkg::REG_PACKET_BURST: begin
        pkt_burst_q = val;
        pkt_bkt.tokens = token_cap(val);
        pkt_bkt.frac = 0;
      end
      dtbp_pkg::REG_BYTE_RATE: byte_rate_q = val;
      dtbp_pkg::REG_BYTE_BURST: begin
        byte_burst_q = val;
        byte_bkt.tokens = token_cap(val);
        byte_bkt.frac = 0;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_policy(input logic [31:0] pr, input logic [31:0] pb,
                            input logic [31:0] br, input logic [31:0] bb);
    write_reg(dtbp_pkg::REG_PACKET_RATE, pr);
    write_reg(dtbp_pkg::REG_PACKET_BURST, pb);
    write_reg(dtbp_pkg::REG_BYTE_RATE, br);
    write_reg(dtbp_pkg::REG_BYTE_BURST, bb);
  endtask

  task automatic queue_packet(input logic [63:0] stamp, input logic [31:0] nbytes);
    packet_t p;
    p.stamp = stamp;
    p.nbytes = nbytes;
    send_q.push_back(p);
  endtask

  // Waits until every item has been sent and answered, then lets the policer settle.
  task automatic wait_idle();
    while (send_q.size() != 0 || pkt_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Stimulus: directed edge cases, then random phases.
  initial begin
    int          p, k, r;
    profile_t    prof;
    logic [63:0] step, stamp, mean_gap, mean_len, top;
    logic [31:0] nbytes, pr, pb, br, bb;
    logic [63:0] t0;

    pkt_bkt.tokens = token_cap(pkt_burst_q);
    pkt_bkt.frac = 0;
    pkt_bkt.last = 0;
    byte_bkt.tokens = token_cap(byte_burst_q);
    byte_bkt.frac = 0;
    byte_bkt.last = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset policy: time standing still at zero, the byte bucket drained
    // exactly, a fractional refill, time going backwards, an oversized packet.
    queue_packet(64'd0, 32'd0);
    queue_packet(64'd0, 32'd2097152);
    queue_packet(64'd1, 32'd1);
    queue_packet(64'd1, 32'd0);
    queue_packet(64'd1000, 32'd1);
    queue_packet(64'd500, 32'd1);
    queue_packet(64'd2_000_000_000, 32'hFFFF_FFFF);
    queue_packet(64'd2_000_000_001, 32'd2097152);
    wait_idle();

    // Packet refill disabled with a burst of three: the fourth packet is dropped.
    write_reg(dtbp_pkg::REG_PACKET_RATE, 32'd0);
    write_reg(dtbp_pkg::REG_PACKET_BURST, 32'd3);
    queue_packet(64'd3_000_000_000, 32'd1);
    queue_packet(64'd4_000_000_000, 32'd1);
    queue_packet(64'd5_000_000_000, 32'd1);
    queue_packet(64'd6_000_000_000, 32'd1);
    wait_idle();

    // A rate write keeps the drained tokens until time moves on.
    write_reg(dtbp_pkg::REG_PACKET_RATE, 32'd1);
    queue_packet(64'd6_500_000_000, 32'd1);
    wait_idle();

    // Zero packet burst rejects everything.
    t0 = 64'd7_000_000_000;
    set_policy('1, 32'd0, '1, '1);
    queue_packet(t0 + 1, 32'd0);
    wait_idle();

    // Full-width burst and length, then a one nanosecond refill at the top rate.
    write_reg(dtbp_pkg::REG_PACKET_BURST, '1);
    queue_packet(t0 + 2, 32'hFFFF_FFFF);
    queue_packet(t0 + 3, 32'd1);
    wait_idle();

    // Byte refill disabled, then a rate of one with whole seconds short of full.
    write_reg(dtbp_pkg::REG_BYTE_RATE, 32'd0);
    queue_packet(t0 + 64'd5_000_000_000, 32'd5);
    wait_idle();
    write_reg(dtbp_pkg::REG_BYTE_RATE, 32'd1);
    queue_packet(t0 + 64'd8_000_000_007, 32'd2);
    wait_idle();

    // Zero byte burst passes only empty packets.
    write_reg(dtbp_pkg::REG_BYTE_BURST, 32'd0);
    queue_packet(t0 + 64'd9_000_000_000, 32'd0);
    queue_packet(t0 + 64'd9_000_000_001, 32'd1);

    // Random phases, each with its own policy and an ever later time base.
    wall_ns = 64'd20_000_000_000;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      prof = profile_t'($urandom_range(0, 3));
      case (prof)
        PROFILE_DEFAULTS: begin
          pr = $urandom_range(500, 5000);
          pb = $urandom_range(1, 4000);
          br = $urandom_range(1 << 16, 1 << 24);
          bb = $urandom_range(1 << 16, 1 << 25);
        end
        PROFILE_TIGHT: begin
          pr = $urandom_range(1, 50);
          pb = $urandom_range(0, 60);
          br = $urandom_range(1, 100000);
          bb = $urandom_range(1, 300000);
        end
        PROFILE_EXTREME: begin
          pr = pick_extreme();
          pb = pick_extreme();
          br = pick_extreme();
          bb = pick_extreme();
        end
        default: begin
          pr = $urandom;
          pb = $urandom;
          br = $urandom;
          bb = $urandom;
        end
      endcase
      set_policy(pr, pb, br, bb);
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);

      // Move the time base up so that the upper timestamp bits get exercised.
      if (p == RANDOM_PHASES - 1) begin
        top = 64'hFFFF_FFFF_FF00_0000;
      end else begin
        top = (64'd1 << (4 + 5 * p)) | ({$urandom, $urandom} >> (60 - 5 * p));
      end
      if (top > wall_ns) wall_ns = top;

      mean_gap = (pr == 0) ? 64'd1_000_000 : NS_IN_SEC / 64'(pr);
      if (mean_gap == 0) mean_gap = 64'd1;
      mean_len = 64'(br) / ((pr == 0) ? 64'd1000 : 64'(pr));
      if (mean_len > 64'h7FFF_FFFF) mean_len = 64'h7FFF_FFFF;

      for (k = 0; k < PHASE_PACKETS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          if (r < 64) begin
            step = 64'($urandom_range(0, 32'(2 * mean_gap)));
          end else if (r < 72) begin
            step = 0;
          end else if (r < 77) begin
            step = 64'($urandom_range(1, 20)) * NS_IN_SEC + 64'($urandom_range(0, 999_999_999));
          end else begin
            step = {$urandom, $urandom} >> $urandom_range(8, 40);
          end
          if (TIME_MAX - wall_ns < step) wall_ns = TIME_MAX;
          else wall_ns = wall_ns + step;
          stamp = wall_ns;
        end else begin
          // Out-of-order timestamp at or below the current time base.
          if (wall_ns == TIME_MAX) stamp = {$urandom, $urandom};
          else stamp = {$urandom, $urandom} % (wall_ns + 64'd1);
        end

        r = $urandom_range(0, 99);
        if (r < 5) nbytes = $urandom;
        else if (r < 8) nbytes = 32'd0;
        else if (r < 10) nbytes = '1;
        else nbytes = $urandom_range(0, 32'(2 * mean_len));
        queue_packet(stamp, nbytes);
      end
      if (p == RANDOM_PHASES - 1) queue_packet(TIME_MAX, $urandom);
    end

    wait_idle();
    repeat (200) @(negedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
